// File: rtl/bspd_pkg.sv
package bspd_pkg;

   // CRC-8, reflected form of polynomial 0x31
   localparam logic [7:0] CRC_POLY = 8'h8C;
   localparam int         BYTE_W   = 8;

   // Configuration register indexes
   localparam logic [1:0] CSR_START  = 2'd0;
   localparam logic [1:0] CSR_END    = 2'd1;
   localparam logic [1:0] CSR_ESCAPE = 2'd2;

   // Configuration reset values
   localparam logic [7:0] START_RST  = 8'h02;
   localparam logic [7:0] END_RST    = 8'h03;
   localparam logic [7:0] ESCAPE_RST = 8'h50;

   // Flow controller states
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_LOAD = 3'b100
   } state_type;

   // Framing mode of the receiver
   typedef enum logic [2:0] {
      MODE_IDLE      = 3'b001,
      MODE_RECEIVING = 3'b010,
      MODE_ESCAPING  = 3'b100
   } mode_type;

   // Controller to datapath
   typedef struct packed {
      logic take;    // request accepted this cycle
      logic rd_en;   // read the store at the flush index
      logic load;    // load the response register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic flush_go;     // incoming byte closes a packet that passed the check
      logic flush_empty;  // that packet has no payload
      logic rd_last;      // response being loaded is the last of its packet
      logic out_free;     // response register can take a new value
   } sts_type;

   // One byte of reflected CRC-8 update
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < BYTE_W; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// File: rtl/bspd_ctrl.sv
module bspd_ctrl
   import bspd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   // Accept requests only while no flush is running
   assign req_ready = (state_ff == ST_IDLE);

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd.take  = 1'b0;
      cmd.rd_en = 1'b0;
      cmd.load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.take = req_valid;
            if (req_valid && sts.flush_go) begin
               state_in = sts.flush_empty ? ST_LOAD : ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            if (sts.out_free) begin
               cmd.load = 1'b1;
               state_in = sts.rd_last ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/bspd_dp.sv
module bspd_dp
   import bspd_pkg::*;
#(
   parameter int PKT_STORE_DEPTH = 64
)(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wr_data,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_last_of_packet,
   output logic       rsp_empty_packet,
   input  cmd_type    cmd,
   output sts_type    sts
);

   localparam int CNT_W = $clog2(PKT_STORE_DEPTH + 1);
   localparam int IDX_W = $clog2(PKT_STORE_DEPTH);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(PKT_STORE_DEPTH);
   localparam logic [CNT_W-1:0] ONE_COUNT  = CNT_W'(1);

   logic [7:0] start_ff, start_in;
   logic [7:0] end_ff, end_in;
   logic [7:0] escape_ff, escape_in;

   mode_type         mode_ff, mode_in;
   logic [7:0]       crc_ff, crc_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic             empty_ff, empty_in;
   logic [7:0]       rd_data_ff;

   logic [7:0] store_mem [PKT_STORE_DEPTH];

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       rsp_empty_ff, rsp_empty_in;

   logic       wr_en;
   logic [7:0] wr_data;
   logic       good_end;

   // Configuration writes; indexes beyond the list are dropped
   always_comb begin
      start_in  = start_ff;
      end_in    = end_ff;
      escape_in = escape_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_START:  start_in  = csr_wr_data;
            CSR_END:    end_in    = csr_wr_data;
            CSR_ESCAPE: escape_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   // Packet closes with a good check and at least one stored byte
   assign good_end = (req_rx_byte != start_ff) && (mode_ff != MODE_IDLE) &&
                     (req_rx_byte == end_ff) && (crc_ff == 8'h00) &&
                     (count_ff != '0);

   // Decode the request byte and advance the framing state
   always_comb begin
      mode_in  = mode_ff;
      crc_in   = crc_ff;
      count_in = count_ff;
      len_in   = len_ff;
      empty_in = empty_ff;
      wr_en    = 1'b0;
      wr_data  = (mode_ff == MODE_ESCAPING) ? ~req_rx_byte : req_rx_byte;
      if (cmd.take) begin
         priority if (req_rx_byte == start_ff) begin
            count_in = '0;
            crc_in   = 8'h00;
            mode_in  = MODE_RECEIVING;
         end else if (mode_ff == MODE_IDLE) begin
            mode_in = MODE_IDLE;
         end else if (req_rx_byte == end_ff) begin
            mode_in  = MODE_IDLE;
            len_in   = count_ff - ONE_COUNT;
            empty_in = (count_ff == ONE_COUNT);
         end else if (req_rx_byte == escape_ff) begin
            mode_in = MODE_ESCAPING;
         end else if (count_ff == FULL_COUNT) begin
            // drop the packet on overflow
            mode_in = MODE_IDLE;
         end else begin
            wr_en    = 1'b1;
            count_in = count_ff + ONE_COUNT;
            crc_in   = crc8_update(crc_ff, wr_data);
            mode_in  = MODE_RECEIVING;
         end
      end
   end

   // Flush index: restart on a good end, advance on each load
   always_comb begin
      rd_idx_in = rd_idx_ff;
      if (cmd.take && good_end) begin
         rd_idx_in = '0;
      end else if (cmd.load) begin
         rd_idx_in = rd_idx_ff + IDX_W'(1);
      end
   end

   // Response register with its own valid; refill as it drains
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_empty_in = rsp_empty_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = empty_ff ? 8'h00 : rd_data_ff;
         rsp_last_in  = sts.rd_last;
         rsp_empty_in = empty_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign sts.flush_go    = good_end;
   assign sts.flush_empty = (count_ff == ONE_COUNT);
   assign sts.rd_last     = empty_ff || ((CNT_W'(rd_idx_ff) + ONE_COUNT) == len_ff);
   assign sts.out_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_payload_byte   = rsp_byte_ff;
   assign rsp_last_of_packet = rsp_last_ff;
   assign rsp_empty_packet   = rsp_empty_ff;

   // Packet store: write at the fill count, registered read at the flush index
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[count_ff[IDX_W-1:0]] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= store_mem[rd_idx_ff];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= START_RST;
         end_ff       <= END_RST;
         escape_ff    <= ESCAPE_RST;
         mode_ff      <= MODE_IDLE;
         crc_ff       <= 8'h00;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff     <= start_in;
         end_ff       <= end_in;
         escape_ff    <= escape_in;
         mode_ff      <= mode_in;
         crc_ff       <= crc_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      len_ff       <= len_in;
      empty_ff     <= empty_in;
      rd_idx_ff    <= rd_idx_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
   end

endmodule

// File: rtl/byte_stuffed_packet_deframer_crc8.sv
// Channel   Direction  Handshake              Fields
// request   in         req_valid/req_ready    req_rx_byte
// response  out        rsp_valid/rsp_ready    rsp_payload_byte, rsp_last_of_packet,
//                                             rsp_empty_packet
// config    in         csr_wr_en              csr_index, csr_wr_data
//
// A byte that stores, escapes or is dropped keeps req_ready high. A good end byte
// starts a flush in which, for each payload byte, the controller does a store read
// then a response load; an empty packet gets a response load only. The flush stalls
// while the response register is full and not drained. No request is taken during
// it. Reset is synchronous; it restores the register defaults and clears the framing
// state. Only entries of the current packet are read.
module byte_stuffed_packet_deframer_crc8
   import bspd_pkg::*;
#(
   parameter int PKT_STORE_DEPTH = 64
)(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wr_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_last_of_packet,
   output logic       rsp_empty_packet
);

   cmd_type cmd;
   sts_type sts;

   // Flow controller
   bspd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Framing, CRC, store and response register
   bspd_dp #(
      .PKT_STORE_DEPTH (PKT_STORE_DEPTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_last_of_packet (rsp_last_of_packet),
      .rsp_empty_packet   (rsp_empty_packet),
      .cmd                (cmd),
      .sts                (sts)
   );

endmodule
